// ===== rtl/core/mbpf_pkg.sv =====
`timescale 1ns / 1ps

package mbpf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int COORD_W     = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int HIT_W       = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_LEFT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_TOP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_WIDTH    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_HEIGHT   = 3'd5;

  // result slots of one item, in delivery order
  localparam int HIT_PREV_COL_PREV_ROW = 0;
  localparam int HIT_PREV_COL_CUR_ROW  = 1;
  localparam int HIT_CUR_COL_PREV_ROW  = 2;
  localparam int HIT_CUR_COL_CUR_ROW   = 3;
  localparam int HIT_MARKER            = 4;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [11:0] roi_left;
    logic [11:0] roi_top;
    logic [12:0] roi_width;
    logic [12:0] roi_height;
  } mbpf_cfg_t;

  typedef struct packed {
    logic [HIT_W-1:0]   hits;
    logic [COORD_W-1:0] x_prev;
    logic [COORD_W-1:0] x_cur;
    logic [COORD_W-1:0] y_prev;
    logic [COORD_W-1:0] y_cur;
  } mbpf_bundle_t;

  // foreground centre with a background neighbour that lies in both window and image
  function automatic logic mbpf_boundary(input logic [8:0] win, input int wr, input int wc,
                                         input logic xlo_ok, input logic xhi_ok,
                                         input logic ylo_ok, input logic yhi_ok);
    int   nr;
    int   nc;
    logic hit;
    logic img_ok;
    hit = 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = wr + dr;
        nc = wc + dc;
        img_ok = (dc != -1 || xlo_ok) && (dc != 1 || xhi_ok) &&
                 (dr != -1 || ylo_ok) && (dr != 1 || yhi_ok);
        if ((dr != 0 || dc != 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2 && img_ok) begin
          if (!win[nr*3+nc]) begin
            hit = 1'b1;
          end
        end
      end
    end
    return win[wr*3+wc] && hit;
  endfunction

endpackage

// ===== rtl/core/mbpf_ram.sv =====
`timescale 1ns / 1ps

module mbpf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mbpf_front.sv =====
`timescale 1ns / 1ps

module mbpf_front import mbpf_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mbpf_cfg_t                          cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         mask_value,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
  output logic                               push,
  output mbpf_bundle_t                       push_bundle
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WB  = $clog2(MAX_WIDTH + 1) + 1;
  localparam int HB  = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int CW0 = (WB > 14) ? WB : 14;
  localparam int CW  = (HB > CW0) ? HB : CW0;
  localparam int QW  = $clog2(QUEUE_DEPTH + 1);

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          clearing;
  logic [XW-1:0] clr_addr;
  logic [8:0]    window;

  logic          s1_valid;
  logic [XW-1:0] s1_col;
  logic [YW-1:0] s1_row;
  logic          s1_fg;
  logic          s1_last_col;
  logic          s1_last_row;
  logic          s1_fwd;
  logic [1:0]    s1_fwd_data;

  logic [CW-1:0] eff_w, eff_h, iw, ih;
  logic          restart, accept, last_col, last_row;
  logic [XW-1:0] c_sel;
  logic [YW-1:0] r_sel;

  logic [1:0]    rd_data, line;
  logic          la, l2;
  logic [8:0]    window_next;
  logic          ram_we;
  logic [XW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;

  logic [CW-1:0] cx, ry, x_prev, y_prev, x_end, y_end;
  logic          has_c1, has_r1, c_ge2, r_ge2;
  logic          roi_xp, roi_xc, roi_yp, roi_yc;
  logic [HIT_W-1:0] hits;

  always_comb begin
    iw = CW'(cfg.image_width);
    ih = CW'(cfg.image_height);
    if (iw == '0) begin
      eff_w = CW'(1);
    end else if (iw > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = iw;
    end
    if (ih == '0) begin
      eff_h = CW'(1);
    end else if (ih > CW'(MAX_HEIGHT)) begin
      eff_h = CW'(MAX_HEIGHT);
    end else begin
      eff_h = ih;
    end
    restart  = (CW'(col) >= eff_w) || (CW'(row) >= eff_h);
    c_sel    = restart ? '0 : col;
    r_sel    = restart ? '0 : row;
    last_col = (CW'(c_sel) + CW'(1)) == eff_w;
    last_row = (CW'(r_sel) + CW'(1)) == eff_h;
  end

  assign in_ready = !clearing && ((QW+1)'(q_count) + (QW+1)'(s1_valid) < (QW+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  assign line        = s1_fwd ? s1_fwd_data : rd_data;
  assign la          = line[0];
  assign l2          = line[1];
  assign window_next = ((window >> 1) & 9'h0DB) | {s1_fg, 2'b00, la, 2'b00, l2, 2'b00};

  assign ram_we    = clearing || s1_valid;
  assign ram_waddr = clearing ? clr_addr : s1_col;
  assign ram_wdata = clearing ? 2'b00 : {la, s1_fg};

  mbpf_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (c_sel),
    .rd_data (rd_data)
  );

  always_comb begin
    cx     = CW'(s1_col);
    ry     = CW'(s1_row);
    x_prev = cx - CW'(1);
    y_prev = ry - CW'(1);
    has_c1 = s1_col != '0;
    has_r1 = s1_row != '0;
    c_ge2  = cx > CW'(1);
    r_ge2  = ry > CW'(1);
    x_end  = CW'(cfg.roi_left) + CW'(cfg.roi_width);
    y_end  = CW'(cfg.roi_top) + CW'(cfg.roi_height);
    roi_xp = (x_prev >= CW'(cfg.roi_left)) && (x_prev < x_end);
    roi_xc = (cx >= CW'(cfg.roi_left)) && (cx < x_end);
    roi_yp = (y_prev >= CW'(cfg.roi_top)) && (y_prev < y_end);
    roi_yc = (ry >= CW'(cfg.roi_top)) && (ry < y_end);
    hits = '0;
    hits[HIT_PREV_COL_PREV_ROW] = has_c1 && has_r1 && roi_xp && roi_yp &&
        mbpf_boundary(window_next, 1, 1, c_ge2, 1'b1, r_ge2, 1'b1);
    hits[HIT_PREV_COL_CUR_ROW] = has_c1 && s1_last_row && roi_xp && roi_yc &&
        mbpf_boundary(window_next, 2, 1, c_ge2, 1'b1, has_r1, 1'b0);
    hits[HIT_CUR_COL_PREV_ROW] = s1_last_col && has_r1 && roi_xc && roi_yp &&
        mbpf_boundary(window_next, 1, 2, has_c1, 1'b0, r_ge2, 1'b1);
    hits[HIT_CUR_COL_CUR_ROW] = s1_last_col && s1_last_row && roi_xc && roi_yc &&
        mbpf_boundary(window_next, 2, 2, has_c1, 1'b0, has_r1, 1'b0);
    hits[HIT_MARKER] = s1_last_col && s1_last_row;
    push_bundle.hits   = hits;
    push_bundle.x_prev = x_prev[COORD_W-1:0];
    push_bundle.x_cur  = cx[COORD_W-1:0];
    push_bundle.y_prev = y_prev[COORD_W-1:0];
    push_bundle.y_cur  = ry[COORD_W-1:0];
  end

  assign push = s1_valid && (hits != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      window   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == XW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (s1_valid) begin
        window <= window_next;
      end
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : r_sel + 1'b1;
        end else begin
          col <= c_sel + 1'b1;
          row <= r_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= c_sel;
      s1_row      <= r_sel;
      s1_fg       <= |mask_value;
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      s1_fwd      <= s1_valid && (s1_col == c_sel);
      s1_fwd_data <= {la, s1_fg};
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last_col && s1_last_row) |-> (col == '0 && row == '0))
    else $error("counters not back at frame start after last pixel");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !s1_valid)
    else $error("item entered the window during the line store clear");

endmodule

// ===== rtl/core/mbpf_queue.sv =====
`timescale 1ns / 1ps

module mbpf_queue import mbpf_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  mbpf_bundle_t                     push_bundle,
  input  logic                             pop,
  output mbpf_bundle_t                     head,
  output logic                             not_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  mbpf_bundle_t  entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
    else $error("item pushed into full queue");

endmodule

// ===== rtl/core/mbpf_back.sv =====
`timescale 1ns / 1ps

module mbpf_back import mbpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mbpf_bundle_t       head,
  input  logic               not_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] point_x,
  output logic [COORD_W-1:0] point_y,
  output logic               is_point,
  output logic               last_of_run
);

  logic [HIT_W-1:0] done;
  logic [HIT_W-1:0] remaining;
  logic [HIT_W-1:0] sel;
  logic [HIT_W-1:0] rest;
  logic             load;

  assign remaining = head.hits & ~done;
  assign sel       = remaining & (~remaining + 1'b1);
  assign rest      = remaining & ~sel;
  assign load      = not_empty && (!out_valid || out_ready);
  assign pop       = load && (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= (rest == '0) ? '0 : (done | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_point    <= !sel[HIT_MARKER];
      last_of_run <= rest == '0;
      if (sel[HIT_PREV_COL_PREV_ROW]) begin
        point_x <= head.x_prev;
        point_y <= head.y_prev;
      end else if (sel[HIT_PREV_COL_CUR_ROW]) begin
        point_x <= head.x_prev;
        point_y <= head.y_cur;
      end else if (sel[HIT_CUR_COL_PREV_ROW]) begin
        point_x <= head.x_cur;
        point_y <= head.y_prev;
      end else if (sel[HIT_CUR_COL_CUR_ROW]) begin
        point_x <= head.x_cur;
        point_y <= head.y_cur;
      end else begin
        point_x <= '0;
        point_y <= '0;
      end
    end
  end

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && last_of_run))
    else $error("bundle retired without a closing result");

  a_head_not_spent: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> (remaining != '0))
    else $error("queue head has no results left");

endmodule

// ===== rtl/core/mask_boundary_point_finder_top.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[12:0]
// in       in         in_valid/in_ready    mask_value[7:0]
// out      out        out_valid/out_ready  point_x[11:0], point_y[11:0], is_point, last_of_run
//
// One mask item per cycle enters while in_ready is high; its window is built in the next cycle from a registered
// line store read, and its results go to a four-bundle queue.
// Each item yields zero to five results; the output stage sends one result per cycle while
// out_ready is high, and the queue lets new items enter before earlier results are all sent.
// After reset all MAX_WIDTH line store entries are cleared, with in_ready low.
// A stalled output fills the queue and then drops in_ready; cfg_ready is always high.

module mask_boundary_point_finder_top import mbpf_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             mask_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_W-1:0]     point_x,
  output logic [COORD_W-1:0]     point_y,
  output logic                   is_point,
  output logic                   last_of_run
);

  mbpf_cfg_t    cfg;
  logic         push;
  mbpf_bundle_t push_bundle;
  logic         pop;
  mbpf_bundle_t head;
  logic         not_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= 13'd640;
      cfg.image_height <= 13'd480;
      cfg.roi_left     <= 12'd0;
      cfg.roi_top      <= 12'd0;
      cfg.roi_width    <= 13'd640;
      cfg.roi_height   <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_ROI_LEFT:     cfg.roi_left     <= cfg_data[11:0];
        REG_ROI_TOP:      cfg.roi_top      <= cfg_data[11:0];
        REG_ROI_WIDTH:    cfg.roi_width    <= cfg_data;
        REG_ROI_HEIGHT:   cfg.roi_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbpf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mask_value  (mask_value),
    .q_count     (q_count),
    .push        (push),
    .push_bundle (push_bundle)
  );

  mbpf_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .not_empty   (not_empty),
    .count       (q_count)
  );

  mbpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .not_empty   (not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .is_point    (is_point),
    .last_of_run (last_of_run)
  );

endmodule

// ===== sim/mbpf_checker.sv =====
`timescale 1ns / 1ps

module mbpf_checker import mbpf_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             mask_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [COORD_W-1:0]     point_x,
  input  logic [COORD_W-1:0]     point_y,
  input  logic                   is_point,
  input  logic                   last_of_run,
  output int                     fail_count,
  output int                     pending,
  output int                     points_seen,
  output int                     markers_seen
);

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               is_point;
    logic               last;
  } point_rec_t;

  point_rec_t  expected_points[$];

  logic [12:0] img_w_reg;
  logic [12:0] img_h_reg;
  logic [11:0] roi_l_reg;
  logic [11:0] roi_t_reg;
  logic [12:0] roi_w_reg;
  logic [12:0] roi_h_reg;
  logic        row_above [MAX_WIDTH];
  logic        row_two_above [MAX_WIDTH];
  logic [8:0]  window;
  int          col_pos;
  int          row_pos;
  int          mismatches = 0;
  int          n_points = 0;
  int          n_markers = 0;

  function automatic logic in_roi(input int x, input int y, input int w, input int h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    if (x < int'(roi_l_reg) || x >= int'(roi_l_reg) + int'(roi_w_reg)) return 1'b0;
    if (y < int'(roi_t_reg) || y >= int'(roi_t_reg) + int'(roi_h_reg)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic is_border_pixel(input int x, input int y, input int wr, input int wc,
                                           input int w, input int h);
    int nr;
    int nc;
    if (!window[wr*3+wc]) return 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = wr + dr;
        nc = wc + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2 &&
            x + dc >= 0 && x + dc < w && y + dr >= 0 && y + dr < h) begin
          if (!window[nr*3+nc]) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_points(input logic [7:0] value);
    int         w;
    int         h;
    int         c;
    int         r;
    int         x;
    logic       fg;
    logic       la;
    logic       l2;
    point_rec_t rec;
    point_rec_t found[$];
    w = int'(img_w_reg);
    h = int'(img_h_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c  = col_pos;
    r  = row_pos;
    fg = (value != 8'd0);
    la = row_above[c];
    l2 = row_two_above[c];
    row_two_above[c] = la;
    row_above[c]     = fg;
    window = ((window >> 1) & 9'h0DB) | {fg, 2'b00, la, 2'b00, l2, 2'b00};
    rec.is_point = 1'b1;
    rec.last     = 1'b0;
    for (int k = 0; k < 2; k++) begin
      x = c - 1 + k;
      if ((k == 0 || c == w - 1) && x >= 0) begin
        rec.x = x[COORD_W-1:0];
        if (r >= 1 && in_roi(x, r - 1, w, h) && is_border_pixel(x, r - 1, 1, k + 1, w, h)) begin
          rec.y = COORD_W'(r - 1);
          found.insert(found.size(), rec);
        end
        if (r == h - 1 && in_roi(x, r, w, h) && is_border_pixel(x, r, 2, k + 1, w, h)) begin
          rec.y = COORD_W'(r);
          found.insert(found.size(), rec);
        end
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        rec = '0;
        found.insert(found.size(), rec);
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_points.insert(expected_points.size(), found[i]);
  endtask

  task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result();
    point_rec_t want;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("result with nothing expected: point_x=%0d point_y=%0d is_point=%0b",
               point_x, point_y, is_point);
      return;
    end
    want = expected_points.pop_front();
    if (want.is_point) n_points++;
    else n_markers++;
    compare_field("point_x", want.x, point_x);
    compare_field("point_y", want.y, point_y);
    compare_field("is_point", COORD_W'(want.is_point), COORD_W'(is_point));
    compare_field("last_of_run", COORD_W'(want.last), COORD_W'(last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      img_w_reg = 13'd640;
      img_h_reg = 13'd480;
      roi_l_reg = 12'd0;
      roi_t_reg = 12'd0;
      roi_w_reg = 13'd640;
      roi_h_reg = 13'd480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i]     = 1'b0;
        row_two_above[i] = 1'b0;
      end
      window  = '0;
      col_pos = 0;
      row_pos = 0;
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_points(mask_value);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w_reg = cfg_data;
          REG_IMAGE_HEIGHT: img_h_reg = cfg_data;
          REG_ROI_LEFT:     roi_l_reg = cfg_data[11:0];
          REG_ROI_TOP:      roi_t_reg = cfg_data[11:0];
          REG_ROI_WIDTH:    roi_w_reg = cfg_data;
          REG_ROI_HEIGHT:   roi_h_reg = cfg_data;
          default: begin
          end
        endcase
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_points.size();
    points_seen  <= n_points;
    markers_seen <= n_markers;
  end

endmodule

// ===== sim/tb_mask_boundary_point_finder_top.sv =====
`timescale 1ns / 1ps

module tb_mask_boundary_point_finder_top;
  import mbpf_pkg::*;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int RESET_ITEMS    = 24;
  localparam int EDGE_ITEMS     = 24;
  localparam int RANDOM_ITEMS   = 230;
  localparam int MAX_GAP        = 13;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [71:0]            RING_FRAME   = 72'hFF_01_80_7F_00_FE_10_02_40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             mask_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COORD_W-1:0]     point_x;
  logic [COORD_W-1:0]     point_y;
  logic                   is_point;
  logic                   last_of_run;

  int fail_count;
  int pending;
  int points_seen;
  int markers_seen;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int frame_w;
  int frame_h;
  int items_sent = 0;
  int settings_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mask_boundary_point_finder_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mask_value  (mask_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .is_point    (is_point),
    .last_of_run (last_of_run)
  );

  mbpf_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mask_value   (mask_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .is_point     (is_point),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .pending      (pending),
    .points_seen  (points_seen),
    .markers_seen (markers_seen)
  );

  task automatic send_pixel(input logic [7:0] value);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mask_value <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixels(input int count, input int density);
    for (int i = 0; i < count; i++) begin
      // hold off now and then until the block has emptied
      if (!tx_steady && $urandom_range(0, 49) == 0) drain_results();
      send_pixel(($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'd0);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_frame(input int w_raw, h_raw, rl, rt, rw, rh);
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                $urandom_range(0, 8191));
    write_reg(REG_IMAGE_WIDTH, w_raw);
    write_reg(REG_IMAGE_HEIGHT, h_raw);
    write_reg(REG_ROI_LEFT, rl);
    write_reg(REG_ROI_TOP, rt);
    write_reg(REG_ROI_WIDTH, rw);
    write_reg(REG_ROI_HEIGHT, rh);
    cfg_valid <= 1'b0;
    frame_w = (w_raw < 1) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
    frame_h = (h_raw < 1) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
    settings_used++;
  endtask

  function automatic int pick_start(input int span);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 4095;
    if (r < 3) return 0;
    return $urandom_range(0, span);
  endfunction

  function automatic int pick_span(input int span);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8191;
    if (r == 1) return 0;
    if (r < 4) return span;
    return $urandom_range(1, span + 1);
  endfunction

  initial begin : out_side
    int stall;
    @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("** mask_boundary_point_finder_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int w;
    int h;
    int count;
    int random_items;
    random_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // start a frame at the reset geometry
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_pixels(RESET_ITEMS, 30);
    drain_results();

    // shrink below the current position: the frame restarts
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    write_reg(REG_SPARE_LO, 8191);
    write_reg(REG_SPARE_HI, 0);
    set_frame(3, 3, 0, 0, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(RING_FRAME[71-8*i -: 8]);
    for (int i = 0; i < 9; i++) send_pixel(8'($urandom_range(1, 255)));
    drain_results();
    set_frame(0, 0, 4095, 4095, 8191, 8191);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    drain_results();

    // clamped widest row and tallest column
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    set_frame(8191, 1, 0, 0, 8191, 8191);
    send_pixels(EDGE_ITEMS, 10);
    drain_results();
    set_frame(0, 8191, 0, 0, 4096, 4096);
    send_pixels(EDGE_ITEMS, 85);
    drain_results();

    while (random_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      h = (w > 12) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      set_frame((w == 1 && $urandom_range(0, 1) != 0) ? 0 : w, h,
                pick_start(w), pick_start(h), pick_span(w), pick_span(h));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      count = ((w > 12) ? 1 : $urandom_range(1, 3)) * frame_w * frame_h;
      // leave a frame unfinished now and then
      if ($urandom_range(0, 3) == 0 && frame_w * frame_h > 1)
        count += $urandom_range(1, frame_w * frame_h - 1);
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      send_pixels(count, $urandom_range(15, 95));
      random_items += count;
      drain_results();
    end

    $display("Covered %0d mask items over %0d register settings, reset geometry to clamped 4096.",
             items_sent, settings_used);
    $display("Checked %0d boundary points and %0d frame markers.", points_seen, markers_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** mask_boundary_point_finder_top: PASSED **");
    end else begin
      $display("** mask_boundary_point_finder_top: FAILED **");
    end
    $finish;
  end

endmodule
